// ===== hw/rtl/gtp_pkg.sv =====
// Shared types, constants and helpers for the go-to-pose controller.
`default_nettype none
package gtp_pkg;
    localparam int AngPi = 12868;
    localparam int AngTwoPi = 25736;
    localparam int ZHalfPi = 102944;
    localparam int CordicSteps = 16;
    localparam int StepW = 5;
    localparam int SqrtSteps = 17;
    localparam int CfgIdxW = 3;

    localparam logic [CfgIdxW-1:0] REG_POS_WIN   = 3'd0;
    localparam logic [CfgIdxW-1:0] REG_HEAD_WIN  = 3'd1;
    localparam logic [CfgIdxW-1:0] REG_MAX_TURN  = 3'd2;
    localparam logic [CfgIdxW-1:0] REG_MIN_TURN  = 3'd3;
    localparam logic [CfgIdxW-1:0] REG_MAX_SPEED = 3'd4;
    localparam logic [CfgIdxW-1:0] REG_GAIN      = 3'd5;
    localparam logic [CfgIdxW-1:0] REG_DRIVE_WIN = 3'd6;

    typedef enum logic [2:0] {
        ST_IDLE, ST_CHECK, ST_CORDIC, ST_SQRT, ST_FINISH, ST_OUT
    } state_t;

    typedef struct packed {
        logic [14:0] position_window;
        logic [13:0] heading_window;
        logic [13:0] max_turn_rate;
        logic [13:0] min_turn_rate;
        logic [15:0] max_speed;
        logic [7:0]  speed_gain;
        logic [13:0] drive_heading_window;
    } cfg_t;

    function automatic logic [23:0] atan_entry(input logic [StepW-1:0] i);
        logic [23:0] r;
        case (i)
            5'd0: r = 24'd51472;  5'd1: r = 24'd30385;  5'd2: r = 24'd16055;
            5'd3: r = 24'd8150;   5'd4: r = 24'd4091;   5'd5: r = 24'd2047;
            5'd6: r = 24'd1024;   5'd7: r = 24'd512;    5'd8: r = 24'd256;
            5'd9: r = 24'd128;    5'd10: r = 24'd64;    5'd11: r = 24'd32;
            5'd12: r = 24'd16;    5'd13: r = 24'd8;     5'd14: r = 24'd4;
            5'd15: r = 24'd2;
            default: r = 24'd0;
        endcase
        return r;
    endfunction

    function automatic logic signed [18:0] wrap_angle(input logic signed [18:0] e);
        logic signed [18:0] r;
        r = e;
        if (e > 19'sd12868) r = e - 19'sd25736;
        else if (e < -19'sd12868) r = e + 19'sd25736;
        return r;
    endfunction

    function automatic logic [18:0] abs19(input logic signed [18:0] e);
        return e[18] ? 19'(-e) : 19'(e);
    endfunction

    function automatic logic signed [14:0] clamp_turn(input logic signed [18:0] e,
            input logic [13:0] mx, input logic [13:0] mn);
        logic [18:0] mag;
        logic signed [18:0] t;
        mag = abs19(e);
        t = e;
        if (mag > {5'd0, mx}) begin
            mag = {5'd0, mx};
            t = e[18] ? -$signed({5'd0, mx}) : $signed({5'd0, mx});
        end
        if (mag < {5'd0, mn}) t = e[18] ? -$signed({5'd0, mn}) : $signed({5'd0, mn});
        return t[14:0];
    endfunction
endpackage
`default_nettype wire

// ===== hw/rtl/go_to_pose_controller.sv =====
// Top level: go-to-pose steering controller for a differential-drive robot.
// After check, the result beat follows for an input beat inside the window or when arrived;
// when steering the steps are check, CORDIC, square root, finish, then output.
// Throughput: one item in flight; s_tready is low from accept until the m_ beat is taken.
// Reset: synchronous active-low aresetn restores register defaults and sets arrived.
`default_nettype none
module go_to_pose_controller (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // start_req[0], target_x[16:1], target_y[32:17], target_heading[47:33],
    // heading_free[48], robot_x[64:49], robot_y[80:65], robot_heading[95:81]
    input  wire logic [95:0] s_tdata,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // forward_speed[15:0], turn_rate[30:16], done_res[31]
    output logic [31:0]      m_tdata,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [15:0] cfg_data
);
    import gtp_pkg::*;
    state_t state_reg, state_next;
    cfg_t cfg_reg;
    logic arrived_reg, arrived_next;
    logic signed [16:0] dx_reg, dy_reg;
    logic signed [14:0] th_reg, rh_reg;
    logic free_reg;
    logic [15:0] speed_reg, speed_next;
    logic signed [14:0] turn_reg, turn_next;
    logic cordic_go, sqrt_go, cordic_busy, sqrt_busy;
    logic signed [18:0] dir_angle, err_h, err_d;
    logic [16:0] adx, ady, root;
    logic [33:0] sq;
    logic [24:0] prod;
    logic in_window;
    logic drive_ok_reg, drive_ok_next;
    logic accept;

    assign accept = s_tvalid && s_tready;
    assign s_tready = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid = (state_reg == ST_OUT);
    assign m_tdata = {arrived_reg, turn_reg, speed_reg};

    assign adx = dx_reg[16] ? 17'(-dx_reg) : 17'(dx_reg);
    assign ady = dy_reg[16] ? 17'(-dy_reg) : 17'(dy_reg);
    assign in_window = adx < {2'd0, cfg_reg.position_window}
        && ady < {2'd0, cfg_reg.position_window};
    assign err_h = wrap_angle(19'(th_reg) - 19'(rh_reg));
    assign err_d = wrap_angle(((dx_reg == 0 && dy_reg == 0) ? 19'sd0 : dir_angle)
        - 19'(rh_reg));
    assign sq = ({17'd0, adx} * {17'd0, adx}) + ({17'd0, ady} * {17'd0, ady});
    assign prod = 25'(root) * 25'(cfg_reg.speed_gain);

    gtp_cordic u_cordic (.aclk, .aresetn, .start(cordic_go), .dx(dx_reg), .dy(dy_reg),
        .busy(cordic_busy), .angle(dir_angle));
    gtp_sqrt u_sqrt (.aclk, .aresetn, .start(sqrt_go), .value(sq),
        .busy(sqrt_busy), .root(root));

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:   if (accept) state_next = ST_CHECK;
            ST_CHECK:  state_next = (in_window || arrived_reg) ? ST_OUT : ST_CORDIC;
            ST_CORDIC: if (!cordic_busy) state_next = ST_SQRT;
            ST_SQRT:   if (!sqrt_busy) state_next = ST_FINISH;
            ST_FINISH: state_next = ST_OUT;
            ST_OUT:    if (m_tready) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        arrived_next = arrived_reg;
        speed_next = speed_reg;
        turn_next = turn_reg;
        drive_ok_next = drive_ok_reg;
        cordic_go = 1'b0;
        sqrt_go = 1'b0;
        unique case (state_reg)
            ST_IDLE: if (accept && s_tdata[0]) arrived_next = 1'b0;
            ST_CHECK: begin
                speed_next = '0;
                turn_next = '0;
                if (in_window) begin
                    if (abs19(err_h) < {5'd0, cfg_reg.heading_window} || free_reg)
                        arrived_next = 1'b1;
                    else
                        turn_next = clamp_turn(err_h, cfg_reg.max_turn_rate,
                            cfg_reg.min_turn_rate);
                end else if (!arrived_reg) begin
                    cordic_go = 1'b1;
                end
            end
            ST_CORDIC: if (!cordic_busy) begin
                sqrt_go = 1'b1;
                turn_next = clamp_turn(err_d, cfg_reg.max_turn_rate, cfg_reg.min_turn_rate);
                drive_ok_next = abs19(err_d) < {5'd0, cfg_reg.drive_heading_window};
            end
            ST_FINISH: if (drive_ok_reg) begin
                speed_next = (prod[24:8] > {1'b0, cfg_reg.max_speed}) ?
                    cfg_reg.max_speed : prod[23:8];
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            arrived_reg <= 1'b1;
            cfg_reg.position_window <= 15'd50;
            cfg_reg.heading_window <= 14'd410;
            cfg_reg.max_turn_rate <= 14'd2145;
            cfg_reg.min_turn_rate <= 14'd205;
            cfg_reg.max_speed <= 16'd700;
            cfg_reg.speed_gain <= 8'd179;
            cfg_reg.drive_heading_window <= 14'd819;
        end else begin
            state_reg <= state_next;
            arrived_reg <= arrived_next;
            if (cfg_valid) begin
                unique case (cfg_index)
                    REG_POS_WIN:   cfg_reg.position_window <= cfg_data[14:0];
                    REG_HEAD_WIN:  cfg_reg.heading_window <= cfg_data[13:0];
                    REG_MAX_TURN:  cfg_reg.max_turn_rate <= cfg_data[13:0];
                    REG_MIN_TURN:  cfg_reg.min_turn_rate <= cfg_data[13:0];
                    REG_MAX_SPEED: cfg_reg.max_speed <= cfg_data;
                    REG_GAIN:      cfg_reg.speed_gain <= cfg_data[7:0];
                    REG_DRIVE_WIN: cfg_reg.drive_heading_window <= cfg_data[13:0];
                    default: ;
                endcase
            end
        end
        speed_reg <= speed_next;
        turn_reg <= turn_next;
        drive_ok_reg <= drive_ok_next;
        if (accept) begin
            dx_reg <= 17'($signed(s_tdata[16:1])) - 17'($signed(s_tdata[64:49]));
            dy_reg <= 17'($signed(s_tdata[32:17])) - 17'($signed(s_tdata[80:65]));
            th_reg <= s_tdata[47:33];
            free_reg <= s_tdata[48];
            rh_reg <= s_tdata[95:81];
        end
    end

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)) else $error("result dropped");
    a_noacc: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg != ST_IDLE |-> !s_tready) else $error("accept while busy");
    a_arr: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_CORDIC |-> !arrived_reg) else $error("steering while arrived");
endmodule
`default_nettype wire

// ===== hw/rtl/gtp_cordic.sv =====
// Vectoring CORDIC unit, one micro-rotation per cycle.
`default_nettype none
module gtp_cordic (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               start,
    input  wire logic signed [16:0] dx,
    input  wire logic signed [16:0] dy,
    output logic                    busy,
    output logic signed [18:0]      angle
);
    import gtp_pkg::*;
    logic signed [31:0] x_reg, x_next, y_reg, y_next;
    logic signed [23:0] z_reg, z_next;
    logic [StepW-1:0] i_reg, i_next;
    logic busy_reg, busy_next;
    logic signed [31:0] xs, ys, x0, y0;
    logic signed [23:0] zr;

    always_comb begin
        x0 = 32'(dx) <<< 12;
        y0 = 32'(dy) <<< 12;
        xs = x_reg >>> i_reg;
        ys = y_reg >>> i_reg;
        x_next = x_reg; y_next = y_reg; z_next = z_reg;
        i_next = i_reg; busy_next = busy_reg;
        if (start) begin
            busy_next = 1'b1;
            i_next = '0;
            if (dx < 0) begin
                if (dy >= 0) begin
                    x_next = y0; y_next = -x0; z_next = 24'(ZHalfPi);
                end else begin
                    x_next = -y0; y_next = x0; z_next = -24'(ZHalfPi);
                end
            end else begin
                x_next = x0; y_next = y0; z_next = '0;
            end
        end else if (busy_reg) begin
            if (y_reg > 0) begin
                x_next = x_reg + ys; y_next = y_reg - xs;
                z_next = z_reg + $signed(atan_entry(i_reg));
            end else begin
                x_next = x_reg - ys; y_next = y_reg + xs;
                z_next = z_reg - $signed(atan_entry(i_reg));
            end
            i_next = i_reg + 5'd1;
            if (i_reg == StepW'(CordicSteps - 1)) busy_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            i_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            i_reg <= i_next;
        end
        x_reg <= x_next; y_reg <= y_next; z_reg <= z_next;
    end

    assign zr = (z_reg + 24'sd8) >>> 4;
    assign busy = busy_reg;
    assign angle = zr[18:0];

    a_steps: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg && !start |-> i_reg < StepW'(CordicSteps)) else $error("cordic overrun");
endmodule
`default_nettype wire

// ===== hw/rtl/gtp_sqrt.sv =====
// Bit-pair restoring square root, one result bit per cycle.
`default_nettype none
module gtp_sqrt (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        start,
    input  wire logic [33:0] value,
    output logic             busy,
    output logic [16:0]      root
);
    import gtp_pkg::*;
    logic [33:0] v_reg, v_next;
    logic [33:0] r_reg, r_next;
    logic [33:0] b_reg, b_next;
    logic [StepW-1:0] n_reg, n_next;
    logic busy_reg, busy_next;
    logic [33:0] trial;

    always_comb begin
        trial = r_reg + b_reg;
        v_next = v_reg; r_next = r_reg; b_next = b_reg;
        n_next = n_reg; busy_next = busy_reg;
        if (start) begin
            v_next = value; r_next = '0; b_next = 34'h1 << 32;
            n_next = '0; busy_next = 1'b1;
        end else if (busy_reg) begin
            if (v_reg >= trial) begin
                v_next = v_reg - trial;
                r_next = (r_reg >> 1) + b_reg;
            end else begin
                r_next = r_reg >> 1;
            end
            b_next = b_reg >> 2;
            n_next = n_reg + 5'd1;
            if (n_reg == StepW'(SqrtSteps - 1)) busy_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            n_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            n_reg <= n_next;
        end
        v_reg <= v_next; r_reg <= r_next; b_reg <= b_next;
    end

    assign busy = busy_reg;
    assign root = r_reg[16:0];

    a_len: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg && !start |-> n_reg < StepW'(SqrtSteps)) else $error("sqrt overrun");
endmodule
`default_nettype wire

// ===== tb/sv/tb_top.sv =====
// Self-checking stream testbench for the go-to-pose steering controller.
`default_nettype none
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import gtp_pkg::*;

    localparam logic [CfgIdxW-1:0] REG_UNUSED = 3'd7;
    localparam int WatchLimit = 3000;
    localparam int HoldCycles = 400;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [95:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = '0;
    logic [15:0] cfg_data = '0;

    go_to_pose_controller dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    cfg_t        shadow_cfg;
    logic        arrived_model;
    logic [95:0] pose_q[$];
    logic [31:0] steer_q[$];
    logic        in_taken = 1'b0;
    bit          calm = 1'b0;
    int          hold_req = 0;
    int          hold_seen = 0;
    int          hold_cnt = 0;
    int          in_gap = 0;
    int          out_gap = 0;
    int          errors = 0;
    int          beats_in = 0;
    int          beats_out = 0;
    int          done_seen = 0;
    int          drive_seen = 0;
    int          idle_cycles = 0;

    function automatic longint wrap_err(longint e);
        if (e > AngPi) return e - AngTwoPi;
        if (e < -AngPi) return e + AngTwoPi;
        return e;
    endfunction

    function automatic longint clamp_rate(longint e);
        longint sg, mag, t;
        sg = (e < 0) ? -1 : 1;
        mag = (e < 0) ? -e : e;
        t = e;
        if (mag > longint'(shadow_cfg.max_turn_rate)) begin
            t = sg * longint'(shadow_cfg.max_turn_rate);
            mag = longint'(shadow_cfg.max_turn_rate);
        end
        if (mag < longint'(shadow_cfg.min_turn_rate))
            t = sg * longint'(shadow_cfg.min_turn_rate);
        return t;
    endfunction

    function automatic longint bearing(longint dx, longint dy);
        longint atan_w[16] = '{51472, 30385, 16055, 8150, 4091, 2047, 1024, 512,
                               256, 128, 64, 32, 16, 8, 4, 2};
        longint x, y, z, t, xs, ys;
        x = dx * 4096;
        y = dy * 4096;
        z = 0;
        if (dx == 0 && dy == 0) return 0;
        if (x < 0) begin
            t = x;
            if (y >= 0) begin
                x = y; y = -t; z = ZHalfPi;
            end else begin
                x = -y; y = t; z = -ZHalfPi;
            end
        end
        for (int i = 0; i < CordicSteps; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y > 0) begin
                x += ys; y -= xs; z += atan_w[i];
            end else begin
                x -= ys; y += xs; z -= atan_w[i];
            end
        end
        return (z + 8) >>> 4;
    endfunction

    function automatic longint unsigned root_floor(longint unsigned v);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function automatic logic [31:0] steer_predict(logic [95:0] d);
        longint tx, ty, th, rx, ry, rh, dx, dy, e, ae, turn;
        longint unsigned s, speed;
        tx = longint'($signed(d[16:1]));
        ty = longint'($signed(d[32:17]));
        th = longint'($signed(d[47:33]));
        rx = longint'($signed(d[64:49]));
        ry = longint'($signed(d[80:65]));
        rh = longint'($signed(d[95:81]));
        dx = tx - rx;
        dy = ty - ry;
        speed = 0;
        turn = 0;
        if (d[0]) arrived_model = 1'b0;
        if ((dx < 0 ? -dx : dx) < longint'(shadow_cfg.position_window) &&
            (dy < 0 ? -dy : dy) < longint'(shadow_cfg.position_window)) begin
            e = wrap_err(th - rh);
            ae = (e < 0) ? -e : e;
            if (ae < longint'(shadow_cfg.heading_window) || d[48]) arrived_model = 1'b1;
            else turn = clamp_rate(e);
        end else if (!arrived_model) begin
            e = wrap_err(bearing(dx, dy) - rh);
            ae = (e < 0) ? -e : e;
            turn = clamp_rate(e);
            if (ae < longint'(shadow_cfg.drive_heading_window)) begin
                s = (root_floor(longint'(dx * dx + dy * dy)) * shadow_cfg.speed_gain) >> 8;
                speed = (s > shadow_cfg.max_speed) ? shadow_cfg.max_speed : s;
            end
        end
        return {arrived_model, turn[14:0], speed[15:0]};
    endfunction

    function automatic logic [95:0] make_pose(bit st, int tx, int ty, int th, bit hf,
            int rx, int ry, int rh);
        return {15'(rh), 16'(ry), 16'(rx), hf, 15'(th), 16'(ty), 16'(tx), st};
    endfunction

    function automatic logic [95:0] rand_pose();
        int rx, ry, th, rh, span;
        if ($urandom_range(0, 9) == 0)
            return {$urandom(), $urandom(), $urandom()};
        rx = int'($signed(16'($urandom())));
        ry = int'($signed(16'($urandom())));
        case ($urandom_range(0, 2))
            0: span = 80;
            1: span = 3000;
            default: span = 40000;
        endcase
        th = $urandom_range(0, 2 * AngPi) - AngPi;
        rh = $urandom_range(0, 2 * AngPi) - AngPi;
        return make_pose($urandom_range(0, 5) == 0,
                         rx + $urandom_range(0, 2 * span) - span,
                         ry + $urandom_range(0, 2 * span) - span,
                         th, 1'($urandom_range(0, 1)), rx, ry, rh);
    endfunction

    task automatic queue_pose(logic [95:0] p);
        pose_q.insert(pose_q.size(), p);
    endtask

    task automatic reg_write(logic [2:0] idx, logic [15:0] val);
        @(negedge aclk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data = val;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            REG_POS_WIN:   shadow_cfg.position_window = val[14:0];
            REG_HEAD_WIN:  shadow_cfg.heading_window = val[13:0];
            REG_MAX_TURN:  shadow_cfg.max_turn_rate = val[13:0];
            REG_MIN_TURN:  shadow_cfg.min_turn_rate = val[13:0];
            REG_MAX_SPEED: shadow_cfg.max_speed = val;
            REG_GAIN:      shadow_cfg.speed_gain = val[7:0];
            REG_DRIVE_WIN: shadow_cfg.drive_heading_window = val[13:0];
            default: ;
        endcase
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    task automatic write_all(logic [15:0] v[7]);
        reg_write(REG_POS_WIN, v[0]);
        reg_write(REG_HEAD_WIN, v[1]);
        reg_write(REG_MAX_TURN, v[2]);
        reg_write(REG_MIN_TURN, v[3]);
        reg_write(REG_MAX_SPEED, v[4]);
        reg_write(REG_GAIN, v[5]);
        reg_write(REG_DRIVE_WIN, v[6]);
    endtask

    task automatic drain();
        do @(posedge aclk);
        while (pose_q.size() != 0 || s_tvalid || steer_q.size() != 0);
        repeat (50) @(posedge aclk);
    endtask

    // drive input beats
    always @(negedge aclk) begin
        logic nv;
        nv = s_tvalid;
        if (!aresetn) begin
            nv = 1'b0;
        end else if (!s_tvalid || in_taken) begin
            nv = 1'b0;
            if (in_gap > 0) begin
                in_gap--;
            end else if (pose_q.size() != 0) begin
                s_tdata <= pose_q.pop_front();
                nv = 1'b1;
                if (!calm && $urandom_range(0, 7) == 0) in_gap = $urandom_range(1, 10);
            end
        end
        s_tvalid <= nv;
    end

    // drive result-side backpressure
    always @(negedge aclk) begin
        if (hold_req != hold_seen) begin
            hold_seen = hold_req;
            hold_cnt = HoldCycles;
        end
        if (hold_cnt > 0) begin
            hold_cnt--;
            m_tready <= 1'b0;
        end else if (out_gap > 0) begin
            out_gap--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
            if (!calm && $urandom_range(0, 6) == 0) out_gap = $urandom_range(1, 10);
        end
    end

    // predict on input beats, check result beats
    always @(posedge aclk) begin
        logic [31:0] want;
        in_taken <= s_tvalid && s_tready;
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WatchLimit) begin
                $display("%0t: watchdog, no beat for %0d cycles", $time, WatchLimit);
                $display("tb_top: done, errors");
                $finish;
            end
            if (s_tvalid && s_tready) begin
                steer_q.insert(steer_q.size(), steer_predict(s_tdata));
                beats_in++;
            end
            if (m_tvalid && m_tready) begin
                beats_out++;
                if (steer_q.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected beat, actual %h", $time, m_tdata);
                end else begin
                    want = steer_q.pop_front();
                    if (want[31]) done_seen++;
                    if (want[15:0] != 0) drive_seen++;
                    if (want[15:0] != m_tdata[15:0]) begin
                        errors++;
                        $display("%0t: forward_speed expected %0d actual %0d", $time,
                                 want[15:0], m_tdata[15:0]);
                    end
                    if (want[30:16] != m_tdata[30:16]) begin
                        errors++;
                        $display("%0t: turn_rate expected %0d actual %0d", $time,
                                 $signed(want[30:16]), $signed(m_tdata[30:16]));
                    end
                    if (want[31] != m_tdata[31]) begin
                        errors++;
                        $display("%0t: done_res expected %0b actual %0b", $time,
                                 want[31], m_tdata[31]);
                    end
                end
            end
        end
    end

    initial begin
        logic [15:0] v[7];
        shadow_cfg = '{position_window: 15'd50, heading_window: 14'd410,
                       max_turn_rate: 14'd2145, min_turn_rate: 14'd205,
                       max_speed: 16'd700, speed_gain: 8'd179,
                       drive_heading_window: 14'd819};
        arrived_model = 1'b1;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        repeat (5) @(posedge aclk);

        queue_pose(make_pose(0, 1000, 0, 0, 0, 0, 0, 0));
        queue_pose(make_pose(1, 1000, 0, 0, 0, 0, 0, 0));
        queue_pose(make_pose(0, 1000, 0, 0, 0, 0, 0, 6000));
        queue_pose(make_pose(0, -1000, 0, 0, 0, 0, 0, 0));
        queue_pose(make_pose(0, -1000, 5, 0, 0, 0, 0, 12868));
        queue_pose(make_pose(0, -1000, -700, 0, 0, 0, 0, -12868));
        queue_pose(make_pose(0, 32767, -32768, 0, 0, -32768, 32767, 0));
        queue_pose(make_pose(0, -32768, 32767, 0, 0, 32767, -32768, 9000));
        queue_pose(make_pose(0, 0, 2000, 0, 0, 0, 0, 6434));
        queue_pose(make_pose(0, 200, 30, 0, 0, 0, 0, 300));
        queue_pose(make_pose(0, 10, 10, 6000, 0, 0, 0, 0));
        queue_pose(make_pose(0, 10, 10, -6000, 0, 0, 0, 0));
        queue_pose(make_pose(0, 10, -10, 20, 0, 0, 0, 0));
        queue_pose(make_pose(0, 49, -49, 12868, 0, 0, 0, -12868));
        queue_pose(make_pose(1, 5, 5, 5000, 1, 0, 0, 0));
        queue_pose(make_pose(1, 10, 10, 16383, 0, 0, 0, -16384));
        queue_pose(make_pose(0, 10, 10, -16384, 0, 0, 0, 16383));
        queue_pose(make_pose(1, 50, 0, 0, 0, 0, 0, 0));
        queue_pose(make_pose(0, 3000, 4000, 0, 0, 0, 0, 3793));
        drain();

        for (int ph = 0; ph < 8; ph++) begin
            case (ph)
                0: v = '{16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0};
                1: v = '{16'hFFFF, 16'd12868, 16'd12868, 16'd12868, 16'hFFFF, 16'hFF,
                         16'd12868};
                2: v = '{16'd100, 16'd300, 16'd100, 16'd3000, 16'd5000, 16'd255, 16'd2000};
                default: begin
                    foreach (v[k]) v[k] = 16'($urandom_range(0, 400));
                    v[2] = 16'($urandom_range(0, 12868));
                    v[4] = 16'($urandom());
                    v[5] = 16'($urandom_range(0, 255));
                    v[6] = 16'($urandom_range(0, 12868));
                end
            endcase
            write_all(v);
            if (ph == 0) begin
                reg_write(REG_UNUSED, 16'hFFFF);
                queue_pose(make_pose(1, 7, -3, 0, 0, 7, -3, 100));
                queue_pose(make_pose(1, 7, -3, 0, 1, 7, -3, 100));
                queue_pose(make_pose(1, 0, 0, 0, 0, 0, 0, 0));
            end
            if (ph == 2) hold_req++;
            if (ph == 7) calm = 1'b1;
            repeat (204) queue_pose(rand_pose());
            drain();
        end

        $display("covered %0d input beats, %0d results, %0d arrivals, %0d driving",
                 beats_in, beats_out, done_seen, drive_seen);
        $display("register settings: reset, all zero, all max, floor above ceiling, random");
        if (errors == 0) begin
            $display("tb_top: done, clean");
        end else begin
            $display("tb_top: done, errors");
        end
        $finish;
    end
endmodule
`default_nettype wire

// ===== filelist.f =====
hw/rtl/gtp_pkg.sv
hw/rtl/gtp_cordic.sv
hw/rtl/gtp_sqrt.sv
hw/rtl/go_to_pose_controller.sv
tb/sv/tb_top.sv
